// ===== src/positional_insert_extract_array_unit_assert.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef POSITIONAL_INSERT_EXTRACT_ARRAY_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_EXTRACT_ARRAY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIEAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIEAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pieau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pieau_pkg
// Shared constants, codes and types of the positional insert/extract array.
// ----------------------------------------------------------------------------
package pieau_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int DATA_W_DEF = 32;
	localparam int WORD_W     = 32;
	localparam int POS_W      = 8;
	localparam int CAP_W      = 7;
	localparam int LEN_W      = 7;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_EXTRACT = 2'd1,
		MODE_READ    = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_UP,
		S_DOWN,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		logic    busy;
		logic    done;
		status_t status;
	} ctrl_flags_t;

endpackage

// ===== src/pieau_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pieau_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pieau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/pieau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pieau_ctrl
// Sequencer of the array: decodes an item, moves entries through the RAM one
// per cycle with a read/write pipeline, and keeps the entry count.
// ----------------------------------------------------------------------------
module pieau_ctrl #(
	parameter int DEPTH  = pieau_pkg::DEPTH_DEF,
	parameter int DATA_W = pieau_pkg::DATA_W_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               mode,
	input  logic [pieau_pkg::POS_W-1:0]  position,
	input  logic [pieau_pkg::WORD_W-1:0] data_in,
	input  logic [CW-1:0]            cap,
	input  logic                     cfg_we,
	input  logic [CW-1:0]            cfg_cap,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [DATA_W-1:0]        ram_wdata,
	output logic                     ram_re,
	output logic [AW-1:0]            ram_raddr,
	input  logic [DATA_W-1:0]        ram_rdata,
	output pieau_pkg::ctrl_flags_t   flags,
	output logic [pieau_pkg::WORD_W-1:0] data_out,
	output logic [CW-1:0]            count
);

	localparam int POS_W  = pieau_pkg::POS_W;
	localparam int WORD_W = pieau_pkg::WORD_W;
	localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;

	pieau_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     rem_q, rem_d;
	logic              rv_s1, rv_d;

	pieau_pkg::mode_t  mode_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] word_q;
	logic [AW-1:0]     p_q, p_d;
	logic [AW-1:0]     src_q, src_d;
	logic              first_s1, first_d;
	logic [AW-1:0]     wa_s1, wa_d;
	pieau_pkg::status_t status_q, status_d;
	logic [DATA_W-1:0] dout_q, dout_d;

	logic              accept;
	logic [CMP_W-1:0]  pos_x, cnt_x, cap_x;
	logic [CW-1:0]     p_ext;

	assign accept = start && (state_q == pieau_pkg::S_IDLE);
	assign pos_x  = CMP_W'(pos_q);
	assign cnt_x  = CMP_W'(cnt_q);
	assign cap_x  = CMP_W'(cap);
	// Extract at or past the length takes the last entry.
	assign p_ext  = (pos_x >= cnt_x) ? (cnt_q - CW'(1)) : CW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pieau_pkg::S_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			rv_s1   <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= pieau_pkg::mode_t'(mode);
			pos_q  <= position;
			word_q <= DATA_W'(data_in);
		end
		p_q      <= p_d;
		src_q    <= src_d;
		first_s1 <= first_d;
		wa_s1    <= wa_d;
		status_q <= status_d;
		dout_q   <= dout_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		rv_d      = 1'b0;
		p_d       = p_q;
		src_d     = src_q;
		first_d   = 1'b0;
		wa_d      = wa_s1;
		status_d  = status_q;
		dout_d    = dout_q;
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;

		case (state_q)
			pieau_pkg::S_IDLE: begin
				// Entries above a lowered capacity are dropped by clamping the count.
				if (cfg_we && (cnt_q > cfg_cap)) begin
					cnt_d = cfg_cap;
				end
				if (start) begin
					state_d = pieau_pkg::S_DECODE;
				end
			end
			pieau_pkg::S_DECODE: begin
				status_d = pieau_pkg::STAT_OK;
				dout_d   = '0;
				state_d  = pieau_pkg::S_RESP;
				case (mode_q)
					pieau_pkg::MODE_INSERT: begin
						if (pos_x > cap_x) begin
							status_d = pieau_pkg::STAT_RANGE;
						end else if (cnt_x >= cap_x) begin
							status_d = pieau_pkg::STAT_FULL;
						end else begin
							if (pos_x > cnt_x) begin
								p_d   = AW'(cnt_q);
								rem_d = '0;
							end else begin
								p_d   = AW'(pos_q);
								rem_d = cnt_q - CW'(pos_q);
							end
							src_d   = AW'(cnt_q - CW'(1));
							state_d = pieau_pkg::S_UP;
						end
					end
					pieau_pkg::MODE_EXTRACT: begin
						if (cnt_q == '0) begin
							status_d = pieau_pkg::STAT_EMPTY;
						end else begin
							p_d     = AW'(p_ext);
							src_d   = AW'(p_ext);
							rem_d   = cnt_q - p_ext;
							state_d = pieau_pkg::S_DOWN;
						end
					end
					pieau_pkg::MODE_READ: begin
						if (pos_x >= cap_x) begin
							status_d = pieau_pkg::STAT_RANGE;
						end else if (pos_x < cnt_x) begin
							p_d     = AW'(pos_q);
							src_d   = AW'(pos_q);
							rem_d   = CW'(1);
							state_d = pieau_pkg::S_DOWN;
						end
						// Slots at or above the count always read as zero.
					end
					default: begin
						cnt_d = '0;
					end
				endcase
			end
			pieau_pkg::S_UP: begin
				// Read slot i-1 this cycle, write it to slot i the next.
				if (rem_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = src_q;
					rv_d      = 1'b1;
					wa_d      = src_q + AW'(1);
					src_d     = src_q - AW'(1);
					rem_d     = rem_q - CW'(1);
				end
				if (rv_s1) begin
					ram_we    = 1'b1;
					ram_waddr = wa_s1;
					ram_wdata = ram_rdata;
				end else if (rem_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = p_q;
					ram_wdata = word_q;
					cnt_d     = cnt_q + CW'(1);
					state_d   = pieau_pkg::S_RESP;
				end
			end
			pieau_pkg::S_DOWN: begin
				// The first read returns the item's data; later reads move down by one.
				if (rem_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = src_q;
					rv_d      = 1'b1;
					first_d   = (src_q == p_q);
					wa_d      = src_q - AW'(1);
					src_d     = src_q + AW'(1);
					rem_d     = rem_q - CW'(1);
				end
				if (rv_s1) begin
					if (first_s1) begin
						dout_d = ram_rdata;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = wa_s1;
						ram_wdata = ram_rdata;
					end
				end else if (rem_q == '0) begin
					if (mode_q == pieau_pkg::MODE_EXTRACT) begin
						cnt_d = cnt_q - CW'(1);
					end
					state_d = pieau_pkg::S_RESP;
				end
			end
			pieau_pkg::S_RESP: begin
				state_d = pieau_pkg::S_IDLE;
			end
			default: begin
				state_d = pieau_pkg::S_IDLE;
			end
		endcase
	end

	assign flags.busy   = (state_q != pieau_pkg::S_IDLE);
	assign flags.done   = (state_q == pieau_pkg::S_RESP);
	assign flags.status = status_q;
	assign data_out     = WORD_W'(dout_q);
	assign count        = cnt_q;

endmodule

// ===== src/positional_insert_extract_array_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_extract_array_unit
// Ordered array of data words with a length count, kept in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high and cannot be held off.
// Entries move through the RAM at one entry per cycle (one read and one write
// each cycle). An insert moves the N entries at and above its position up and
// then writes its word; an extract reads its entry and moves the N entries
// above it down. The longest item is an extract of the first of DEPTH
// entries. A read of a stored entry fetches it from the RAM; clear, refused
// items and reads of unused slots go from decode straight to the result.
// Busy always falls between items.
// The capacity register may be written only while busy is low.
module positional_insert_extract_array_unit #(
	parameter int DEPTH  = pieau_pkg::DEPTH_DEF,
	parameter int DATA_W = pieau_pkg::DATA_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [pieau_pkg::POS_W-1:0]    position,
	input  logic [pieau_pkg::WORD_W-1:0]   data_in,
	input  logic                           cfg_we,
	input  logic [pieau_pkg::CAP_W-1:0]    cfg_wdata,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [pieau_pkg::WORD_W-1:0]   data_out,
	output logic [pieau_pkg::LEN_W-1:0]    length,
	output logic                           is_full,
	output logic                           is_empty
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CAP_W = pieau_pkg::CAP_W;
	localparam int LEN_W = pieau_pkg::LEN_W;
	localparam int CFG_X = (CW > CAP_W) ? CW : CAP_W;

	logic [CW-1:0]          cap_q;
	logic [CW-1:0]          cap_new;
	logic [CFG_X-1:0]       cfg_x;
	logic [CW-1:0]          count;
	pieau_pkg::ctrl_flags_t flags;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DATA_W-1:0]      ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [DATA_W-1:0]      ram_rdata;

	// A written capacity of zero counts as one; anything above DEPTH as DEPTH.
	assign cfg_x   = CFG_X'(cfg_wdata);
	assign cap_new = (cfg_x == '0) ? CW'(1) :
	                 (cfg_x > CFG_X'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= cap_new;
		end
	end

	pieau_ctrl #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.position  (position),
		.data_in   (data_in),
		.cap       (cap_q),
		.cfg_we    (cfg_we),
		.cfg_cap   (cap_new),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.flags     (flags),
		.data_out  (data_out),
		.count     (count)
	);

	pieau_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy     = flags.busy;
	assign done     = flags.done;
	assign status   = flags.status;
	assign length   = LEN_W'(count);
	assign is_full  = (count == cap_q);
	assign is_empty = (count == '0);

endmodule

// ===== src/pieau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pieau_checker
// Port-level checks of the array unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_insert_extract_array_unit_assert.svh"

module pieau_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [1:0]                   status,
	input logic [pieau_pkg::WORD_W-1:0] data_out,
	input logic [pieau_pkg::LEN_W-1:0]  length,
	input logic                         is_full,
	input logic                         is_empty
);

	`PIEAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`PIEAU_ASSERT_NEXT(a_done_release, done, !done && !busy, "unit did not return to idle")
	`PIEAU_ASSERT_NOW(a_err_zero, done && (status != pieau_pkg::STAT_OK), data_out == '0, "refused item carries data")
	`PIEAU_ASSERT_NOW(a_empty_flag, done, is_empty == (length == '0), "empty flag disagrees with length")
	`PIEAU_ASSERT_NOW(a_full_flag, done && (status == pieau_pkg::STAT_FULL), is_full && !is_empty, "full refusal without full flag")

endmodule

bind positional_insert_extract_array_unit pieau_checker u_pieau_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert/extract array unit.
// ----------------------------------------------------------------------------
// A shadow copy of the array and its length predicts every result. Each
// accepted item adds one expected result, and each done strobe is checked
// field by field against the oldest one. A short directed run covers the
// refusal and edge cases. Random phases follow, each after a capacity write, with
// fill and drain tides so that the array reaches full and empty often.
module tb;
	import pieau_pkg::*;

	typedef struct packed {
		status_t            stat;
		logic [WORD_W-1:0]  word;
		logic [LEN_W-1:0]   len;
		logic               full;
		logic               empty;
	} array_result_t;

	class insert_extract_scoreboard;
		logic [WORD_W-1:0] shadow_slots [DEPTH_DEF];
		int unsigned       shadow_count;
		int unsigned       shadow_cap;
		array_result_t     expected_results [$];
		int unsigned       results_seen;
		int unsigned       errors;

		function new();
			foreach (shadow_slots[i]) shadow_slots[i] = '0;
			shadow_count = 0;
			shadow_cap = DEPTH_DEF;
			results_seen = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// Out-of-range values are clamped; lowering the capacity trims the
		// length and wipes the slots that fall outside.
		function void set_capacity(logic [CAP_W-1:0] value);
			int unsigned cap_new;
			int unsigned i;
			cap_new = value;
			if (cap_new < 1) cap_new = 1;
			if (cap_new > DEPTH_DEF) cap_new = DEPTH_DEF;
			for (i = cap_new; i < DEPTH_DEF; i++) shadow_slots[i] = '0;
			if (shadow_count > cap_new) shadow_count = cap_new;
			shadow_cap = cap_new;
		endfunction

		function void note_item(mode_t op, logic [POS_W-1:0] pos_in,
				logic [WORD_W-1:0] word_in);
			array_result_t r;
			int unsigned   p;
			int unsigned   i;
			r = '0;
			r.stat = STAT_OK;
			p = pos_in;
			case (op)
			MODE_INSERT: begin
				if (p > shadow_cap) begin
					r.stat = STAT_RANGE;
				end else if (shadow_count >= shadow_cap) begin
					r.stat = STAT_FULL;
				end else begin
					if (p > shadow_count) p = shadow_count;
					for (i = shadow_count; i > p; i--) shadow_slots[i] = shadow_slots[i - 1];
					shadow_slots[p] = word_in;
					shadow_count++;
				end
			end
			MODE_EXTRACT: begin
				if (shadow_count == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					if (p >= shadow_count) p = shadow_count - 1;
					r.word = shadow_slots[p];
					for (i = p; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
					shadow_slots[shadow_count - 1] = '0;
					shadow_count--;
				end
			end
			MODE_READ: begin
				if (p >= shadow_cap) r.stat = STAT_RANGE;
				else r.word = shadow_slots[p];
			end
			default: begin
				foreach (shadow_slots[j]) shadow_slots[j] = '0;
				shadow_count = 0;
			end
			endcase
			r.len = LEN_W'(shadow_count);
			r.full = (shadow_count == shadow_cap);
			r.empty = (shadow_count == 0);
			expected_results.push_back(r);
		endfunction

		task report(string what);
			$display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
			errors++;
		endtask

		task check_result(logic [1:0] got_stat, logic [WORD_W-1:0] got_word,
				logic [LEN_W-1:0] got_len, logic got_full, logic got_empty);
			array_result_t e;
			results_seen++;
			if (expected_results.size() == 0) begin
				report($sformatf("result with none expected: status %0d data %h length %0d",
					got_stat, got_word, got_len));
				return;
			end
			e = expected_results.pop_front();
			if (got_stat !== e.stat)
				report($sformatf("status %0d, expected %0d", got_stat, e.stat));
			if (got_word !== e.word)
				report($sformatf("data_out %h, expected %h", got_word, e.word));
			if (got_len !== e.len)
				report($sformatf("length %0d, expected %0d", got_len, e.len));
			if (got_full !== e.full)
				report($sformatf("is_full %b, expected %b", got_full, e.full));
			if (got_empty !== e.empty)
				report($sformatf("is_empty %b, expected %b", got_empty, e.empty));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          mode = MODE_READ;
	logic [POS_W-1:0]    position = '0;
	logic [WORD_W-1:0]   data_in = '0;
	logic                cfg_we = 1'b0;
	logic [CAP_W-1:0]    cfg_wdata = '0;
	logic                done;
	logic [1:0]          status;
	logic [WORD_W-1:0]   data_out;
	logic [LEN_W-1:0]    length;
	logic                is_full;
	logic                is_empty;

	insert_extract_scoreboard sb;
	int unsigned              random_sent = 0;
	bit                       filling = 1'b1;

	positional_insert_extract_array_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.position  (position),
		.data_in   (data_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.data_out  (data_out),
		.length    (length),
		.is_full   (is_full),
		.is_empty  (is_empty)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(status, data_out, length, is_full, is_empty);
	end

	task automatic send_item(mode_t op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
		start    <= 1'b1;
		mode     <= op;
		position <= pos;
		data_in  <= word;
		do @(posedge clk); while (busy);
		sb.note_item(op, pos, word);
	endtask

	// Holds the sender back until every outstanding result has come home.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic run_directed();
		send_item(MODE_EXTRACT, 8'd0, 32'h0);
		send_item(MODE_READ, 8'd255, 32'h0);
		send_item(MODE_READ, 8'd63, 32'h0);
		send_item(MODE_INSERT, 8'd0, 32'hFFFF_FFFF);
		send_item(MODE_INSERT, 8'd255, 32'h0);
		send_item(MODE_INSERT, 8'd64, 32'hA5A5_A5A5);
		send_item(MODE_INSERT, 8'd0, 32'h0000_0001);
		send_item(MODE_INSERT, 8'd1, 32'h8000_0000);
		send_item(MODE_READ, 8'd3, 32'h0);
		send_item(MODE_EXTRACT, 8'd255, 32'h0);
		send_item(MODE_EXTRACT, 8'd1, 32'h0);
		send_item(MODE_INSERT, 8'd2, 32'h5A5A_5A5A);
		send_item(MODE_CLEAR, 8'd255, 32'hFFFF_FFFF);
		// A capacity of zero is taken as one slot.
		write_capacity(7'd0);
		send_item(MODE_INSERT, 8'd1, 32'hDEAD_BEEF);
		send_item(MODE_INSERT, 8'd0, 32'h0000_0001);
		send_item(MODE_INSERT, 8'd2, 32'h0000_0002);
		send_item(MODE_READ, 8'd1, 32'h0);
		send_item(MODE_READ, 8'd0, 32'h0);
		write_capacity(7'd127);
		send_item(MODE_INSERT, 8'd0, 32'h1111_1111);
		send_item(MODE_INSERT, 8'd0, 32'h2222_2222);
		// Shrinking to two slots drops the third entry and wipes its slot.
		write_capacity(7'd2);
		send_item(MODE_READ, 8'd1, 32'h0);
		write_capacity(7'd64);
		send_item(MODE_READ, 8'd2, 32'h0);
		send_item(MODE_EXTRACT, 8'd0, 32'h0);
		send_item(MODE_EXTRACT, 8'd0, 32'h0);
		send_item(MODE_EXTRACT, 8'd200, 32'h0);
	endtask

	task automatic run_random(int unsigned n_items);
		mode_t            op;
		logic [POS_W-1:0] pos;
		int unsigned      r;
		int unsigned      cap;
		int unsigned      idle_pct;
		for (int unsigned k = 0; k < n_items; k++) begin
			cap = sb.shadow_cap;
			// Tides swing the length between empty and full.
			if (sb.shadow_count == cap && $urandom_range(5) == 0) filling = 1'b0;
			else if (sb.shadow_count == 0 && $urandom_range(5) == 0) filling = 1'b1;
			else if ($urandom_range(79) == 0) filling = !filling;
			r = $urandom_range(99);
			if (filling) begin
				if (r < 60) op = MODE_INSERT;
				else if (r < 80) op = MODE_EXTRACT;
				else if (r < 98) op = MODE_READ;
				else op = MODE_CLEAR;
			end else begin
				if (r < 25) op = MODE_INSERT;
				else if (r < 70) op = MODE_EXTRACT;
				else if (r < 99) op = MODE_READ;
				else op = MODE_CLEAR;
			end
			case ($urandom_range(9))
			0: pos = POS_W'($urandom_range(255));
			1: pos = POS_W'(cap);
			2: pos = POS_W'(cap + 1);
			default: pos = POS_W'($urandom_range(cap));
			endcase
			idle_pct = (random_sent < 500) ? 21 : (random_sent < 1000) ? 67 : 0;
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			send_item(op, pos, $urandom());
			random_sent++;
			if ($urandom_range(59) == 0) wait_idle();
		end
	endtask

	initial begin
		int unsigned caps [10] = '{127, 5, 0, 64, 2, 100, 33, 64, 9, 1};
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int unsigned ph = 0; ph < 12; ph++) begin
			write_capacity(CAP_W'((ph < 10) ? caps[ph] : $urandom_range(127)));
			run_random(125);
		end
		wait_idle();
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
